@@ src/tgs_pkg.sv @@
// Shared types, constants and register codes for the tripod gait sequencer.
package tgs_pkg;

    localparam int NUM_LEGS        = 6;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int ANGLE_W         = 24;
    localparam int SPEED_W         = 16;
    localparam int TGT_W           = 15;
    localparam int TOL_W           = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int LANE_STAGES     = 5;

    // 2*pi in Q32, rounded to nearest at ANGLE_FRAC_BITS fractional bits
    localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
    localparam longint unsigned TWO_PI_FIX =
        (TWO_PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
    localparam int MOD_W = $clog2(TWO_PI_FIX + 1);

    // floor(2^32 / modulus): quotient estimate is exact or one short
    localparam longint unsigned RECIP = (64'd1 << 32) / TWO_PI_FIX;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int MAG_W   = ANGLE_W;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int Q_W     = PROD_W - 32;
    localparam int QM_W    = Q_W + MOD_W;
    localparam int RED_W   = MOD_W + 1;
    localparam int DIST_W  = ((TGT_W > MOD_W) ? TGT_W : MOD_W) + 2;

    localparam logic [MOD_W-1:0]   MOD_V   = MOD_W'(TWO_PI_FIX);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    localparam logic [NUM_LEGS-1:0] ALL_LEGS = {NUM_LEGS{1'b1}};

    // Opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE_OFF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE_LAND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STANCE_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIPOD_A     = 3'd5;

    localparam logic [TOL_W-1:0]    TOL_RESET      = 12'd287;
    localparam logic [NUM_LEGS-1:0] TRIPOD_A_RESET = 6'd25;

    typedef struct packed {
        logic                      opcode;
        logic signed [ANGLE_W-1:0] angle_leg0;
        logic signed [ANGLE_W-1:0] angle_leg1;
        logic signed [ANGLE_W-1:0] angle_leg2;
        logic signed [ANGLE_W-1:0] angle_leg3;
        logic signed [ANGLE_W-1:0] angle_leg4;
        logic signed [ANGLE_W-1:0] angle_leg5;
    } tgs_in_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_leg0;
        logic signed [SPEED_W-1:0] speed_leg1;
        logic signed [SPEED_W-1:0] speed_leg2;
        logic signed [SPEED_W-1:0] speed_leg3;
        logic signed [SPEED_W-1:0] speed_leg4;
        logic signed [SPEED_W-1:0] speed_leg5;
        logic [NUM_LEGS-1:0]       command_mask;
        logic                      all_arrived;
        logic                      phase_parity;
    } tgs_out_t;

    typedef struct packed {
        logic [TGT_W-1:0]          take_off;
        logic [TGT_W-1:0]          take_land;
        logic [TOL_W-1:0]          tolerance;
        logic signed [SPEED_W-1:0] stance_speed;
        logic signed [SPEED_W-1:0] flight_speed;
        logic [NUM_LEGS-1:0]       tripod_a;
    } tgs_cfg_t;

    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
    } tgs_lane_ctl_t;

    typedef struct packed {
        logic load;
        logic item_valid;
        logic opcode;
    } tgs_merge_ctl_t;

endpackage

@@ src/tgs_lane.sv @@
// One leg lane: angle reduction modulo 2*pi and arrival compare against both targets.
module tgs_lane
(
    input  logic                            clk,
    input  tgs_pkg::tgs_lane_ctl_t          ctl,
    input  tgs_pkg::tgs_cfg_t               cfg,
    input  logic signed [tgs_pkg::ANGLE_W-1:0] angle,
    output logic                            hit_off,
    output logic                            hit_land
);
    import tgs_pkg::*;

    logic [MAG_W-1:0]         s1_mag_reg;
    logic                     s1_neg_reg;
    logic [PROD_W-1:0]        s2_prod_reg;
    logic [MAG_W-1:0]         s2_mag_reg;
    logic                     s2_neg_reg;
    logic [MAG_W-1:0]         s3_qm_reg;
    logic [MAG_W-1:0]         s3_mag_reg;
    logic                     s3_neg_reg;
    logic signed [RED_W-1:0]  s4_red_reg;
    logic                     s5_off_reg;
    logic                     s5_land_reg;

    logic [MAG_W-1:0]         mag_next;
    logic [PROD_W-1:0]        prod_next;
    logic [Q_W-1:0]           quot;
    logic [QM_W-1:0]          qm_full;
    logic [MAG_W-1:0]         rem_raw;
    logic [MOD_W-1:0]         rem;
    logic signed [RED_W-1:0]  red_next;
    logic signed [DIST_W-1:0] red_ext;
    logic signed [DIST_W-1:0] diff_off;
    logic signed [DIST_W-1:0] diff_land;
    logic [DIST_W-1:0]        abs_off;
    logic [DIST_W-1:0]        abs_land;
    logic [DIST_W-1:0]        tol_ext;

    always_comb
    begin
        // magnitude of the angle; the remainder takes the angle's sign
        mag_next  = angle[ANGLE_W-1] ? (~MAG_W'(angle) + MAG_W'(1)) : MAG_W'(angle);
        prod_next = PROD_W'(s1_mag_reg) * PROD_W'(RECIP_V);
        quot      = s2_prod_reg[PROD_W-1:32];
        qm_full   = QM_W'(quot) * QM_W'(MOD_V);
        rem_raw   = s3_mag_reg - s3_qm_reg;
        // quotient estimate may be one short: fold once
        if (rem_raw >= MAG_W'(MOD_V))
        begin
            rem = MOD_W'(rem_raw - MAG_W'(MOD_V));
        end
        else
        begin
            rem = MOD_W'(rem_raw);
        end
        red_next  = s3_neg_reg ? -RED_W'(rem) : RED_W'(rem);
        red_ext   = DIST_W'(s4_red_reg);
        diff_off  = $signed(DIST_W'(cfg.take_off)) - red_ext;
        diff_land = $signed(DIST_W'(cfg.take_land)) - red_ext;
        abs_off   = diff_off[DIST_W-1] ? DIST_W'(-diff_off) : DIST_W'(diff_off);
        abs_land  = diff_land[DIST_W-1] ? DIST_W'(-diff_land) : DIST_W'(diff_land);
        tol_ext   = DIST_W'(cfg.tolerance);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s1_mag_reg <= mag_next;
            s1_neg_reg <= angle[ANGLE_W-1];
        end
        if (ctl.load[1])
        begin
            s2_prod_reg <= prod_next;
            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
        end
        if (ctl.load[2])
        begin
            s3_qm_reg  <= qm_full[MAG_W-1:0];
            s3_mag_reg <= s2_mag_reg;
            s3_neg_reg <= s2_neg_reg;
        end
        if (ctl.load[3])
        begin
            s4_red_reg <= red_next;
        end
        if (ctl.load[4])
        begin
            s5_off_reg  <= (abs_off < tol_ext);
            s5_land_reg <= (abs_land < tol_ext);
        end
    end

    assign hit_off  = s5_off_reg;
    assign hit_land = s5_land_reg;

endmodule

@@ src/tgs_merge.sv @@
// Merge stage: gait state, per-leg commands and the result register.
module tgs_merge
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tgs_pkg::tgs_merge_ctl_t       ctl,
    input  tgs_pkg::tgs_cfg_t             cfg,
    input  logic [tgs_pkg::NUM_LEGS-1:0]  hit_off,
    input  logic [tgs_pkg::NUM_LEGS-1:0]  hit_land,
    output logic                          out_valid,
    output tgs_pkg::tgs_out_t             out_data
);
    import tgs_pkg::*;

    logic                      out_valid_reg;
    tgs_out_t                  out_data_reg;
    logic [NUM_LEGS-1:0]       marks_reg;
    logic                      parity_reg;
    logic                      first_reg;

    logic [NUM_LEGS-1:0]       marks_next;
    logic                      parity_next;
    logic                      first_next;
    tgs_out_t                  out_data_next;
    logic signed [SPEED_W-1:0] spd [NUM_LEGS];
    logic [NUM_LEGS-1:0]       cmd;
    logic                      done;
    logic [SPEED_W:0]          st_sum;
    logic signed [SPEED_W-1:0] st_half;
    logic signed [SPEED_W-1:0] a_spd;
    logic signed [SPEED_W-1:0] b_spd;
    logic                      use_off;
    logic                      hit;

    always_comb
    begin
        // stance speed halved, truncated toward zero
        st_sum  = {cfg.stance_speed[SPEED_W-1], cfg.stance_speed}
                + {{SPEED_W{1'b0}}, cfg.stance_speed[SPEED_W-1]};
        st_half = $signed(st_sum[SPEED_W:1]);
        if (!parity_reg)
        begin
            a_spd = first_reg ? st_half : cfg.stance_speed;
            b_spd = cfg.flight_speed;
        end
        else
        begin
            a_spd = cfg.flight_speed;
            b_spd = cfg.stance_speed;
        end

        marks_next  = marks_reg;
        parity_next = parity_reg;
        first_next  = first_reg;
        cmd         = '0;
        done        = 1'b0;
        for (int i = 0; i < NUM_LEGS; i++)
        begin
            spd[i]  = '0;
            use_off = (!parity_reg) == cfg.tripod_a[i];
            hit     = use_off ? hit_off[i] : hit_land[i];
            if (ctl.opcode == OP_START)
            begin
                if (!marks_reg[i])
                begin
                    spd[i] = cfg.tripod_a[i] ? a_spd : b_spd;
                    cmd[i] = 1'b1;
                end
            end
            else if (hit)
            begin
                marks_next[i] = 1'b1;
                cmd[i]        = 1'b1;
            end
        end

        // all legs home: stop everything and advance the phase
        if (marks_next == ALL_LEGS)
        begin
            for (int i = 0; i < NUM_LEGS; i++)
            begin
                spd[i] = '0;
            end
            cmd         = ALL_LEGS;
            marks_next  = '0;
            parity_next = ~parity_reg;
            first_next  = 1'b0;
            done        = 1'b1;
        end

        out_data_next.speed_leg0   = spd[0];
        out_data_next.speed_leg1   = spd[1];
        out_data_next.speed_leg2   = spd[2];
        out_data_next.speed_leg3   = spd[3];
        out_data_next.speed_leg4   = spd[4];
        out_data_next.speed_leg5   = spd[5];
        out_data_next.command_mask = cmd;
        out_data_next.all_arrived  = done;
        out_data_next.phase_parity = parity_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            marks_reg     <= '0;
            parity_reg    <= 1'b0;
            first_reg     <= 1'b1;
        end
        else if (ctl.load)
        begin
            out_valid_reg <= ctl.item_valid;
            if (ctl.item_valid)
            begin
                marks_reg  <= marks_next;
                parity_reg <= parity_next;
                first_reg  <= first_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.item_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/tripod_gait_sequencer_top.sv @@
// Top level of the alternating tripod gait sequencer: config registers, lanes, flow control.
//
// Sequencer for an alternating tripod gait of six rotary legs. A start beat
// (opcode 0) commands stance or flight speed to every leg not yet in position;
// tripods swap roles each phase and the stance speed is halved on the first
// phase. A check beat (opcode 1) reduces each leg's joint angle (Q.12 radians)
// by a truncating remainder modulo 2*pi, compares it with the leg's take-off
// or landing target, and marks legs within tolerance; when all six are marked
// every leg is commanded to zero and the phase toggles. Throughput is one beat
// per clock while out_ready does not stall a result. The first of the five
// stages in each of the six leg lanes (magnitude, reciprocal multiply,
// quotient-times-2*pi multiply, remainder fold, target compare) captures the
// beat at the accepting edge, and the merge stage, which holds the gait state
// and registers the result, loads from the target compare stage. Each stage
// has its own valid bit, so input is accepted while a result waits on out_ready
// as long as any stage has room. Configuration is written through cfg_we,
// cfg_index and cfg_data and should only change while the block is idle.
module tripod_gait_sequencer_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tgs_pkg::tgs_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tgs_pkg::tgs_out_t                 out_data,
    input  logic                              cfg_we,
    input  logic [tgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tgs_pkg::*;

    // Configuration registers
    logic [TGT_W-1:0]          take_off_reg;
    logic [TGT_W-1:0]          take_land_reg;
    logic [TOL_W-1:0]          tolerance_reg;
    logic signed [SPEED_W-1:0] stance_reg;
    logic signed [SPEED_W-1:0] flight_reg;
    logic [NUM_LEGS-1:0]       tripod_a_reg;
    tgs_cfg_t                  cfg;

    // Lane pipeline control
    logic [LANE_STAGES-1:0]    valid_reg;
    logic [LANE_STAGES-1:0]    op_reg;
    logic [LANE_STAGES-1:0]    room;
    logic                      out_free;
    tgs_lane_ctl_t             lane_ctl;
    tgs_merge_ctl_t            merge_ctl;

    logic signed [ANGLE_W-1:0] angle [NUM_LEGS];
    logic [NUM_LEGS-1:0]       hit_off;
    logic [NUM_LEGS-1:0]       hit_land;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_off_reg  <= '0;
            take_land_reg <= '0;
            tolerance_reg <= TOL_RESET;
            stance_reg    <= '0;
            flight_reg    <= '0;
            tripod_a_reg  <= TRIPOD_A_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAKE_OFF:     take_off_reg  <= cfg_data[TGT_W-1:0];
                CFG_TAKE_LAND:    take_land_reg <= cfg_data[TGT_W-1:0];
                CFG_TOLERANCE:    tolerance_reg <= cfg_data[TOL_W-1:0];
                CFG_STANCE_SPEED: stance_reg    <= $signed(cfg_data[SPEED_W-1:0]);
                CFG_FLIGHT_SPEED: flight_reg    <= $signed(cfg_data[SPEED_W-1:0]);
                CFG_TRIPOD_A:     tripod_a_reg  <= cfg_data[NUM_LEGS-1:0];
                default:          ; // unmapped index: drop the write
            endcase
        end
    end

    always_comb
    begin
        cfg.take_off     = take_off_reg;
        cfg.take_land    = take_land_reg;
        cfg.tolerance    = tolerance_reg;
        cfg.stance_speed = stance_reg;
        cfg.flight_speed = flight_reg;
        cfg.tripod_a     = tripod_a_reg;
    end

    // A stage takes a new beat when it is empty or its occupant moves on.
    always_comb
    begin
        out_free               = !out_valid || out_ready;
        room[LANE_STAGES-1]    = !valid_reg[LANE_STAGES-1] || out_free;
        for (int k = LANE_STAGES - 2; k >= 0; k--)
        begin
            room[k] = !valid_reg[k] || room[k+1];
        end
        lane_ctl.load        = room;
        merge_ctl.load       = out_free;
        merge_ctl.item_valid = valid_reg[LANE_STAGES-1];
        merge_ctl.opcode     = op_reg[LANE_STAGES-1];
    end

    assign in_ready = room[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (room[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < LANE_STAGES; k++)
            begin
                if (room[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Opcode rides alongside the lane stages
    always_ff @(posedge clk)
    begin
        if (room[0])
        begin
            op_reg[0] <= in_data.opcode;
        end
        for (int k = 1; k < LANE_STAGES; k++)
        begin
            if (room[k])
            begin
                op_reg[k] <= op_reg[k-1];
            end
        end
    end

    always_comb
    begin
        angle[0] = in_data.angle_leg0;
        angle[1] = in_data.angle_leg1;
        angle[2] = in_data.angle_leg2;
        angle[3] = in_data.angle_leg3;
        angle[4] = in_data.angle_leg4;
        angle[5] = in_data.angle_leg5;
    end

    for (genvar g = 0; g < NUM_LEGS; g++)
    begin : g_lane
        tgs_lane u_lane
        (
            .clk      (clk),
            .ctl      (lane_ctl),
            .cfg      (cfg),
            .angle    (angle[g]),
            .hit_off  (hit_off[g]),
            .hit_land (hit_land[g])
        );
    end

    tgs_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (merge_ctl),
        .cfg       (cfg),
        .hit_off   (hit_off),
        .hit_land  (hit_land),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ src/tgs_checker.sv @@
// Port-level checks for the tripod gait sequencer, bound to the top level.
module tgs_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input tgs_pkg::tgs_out_t out_data
);
    import tgs_pkg::*;

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Phase advance stops every leg
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.all_arrived |->
            out_data.command_mask == ALL_LEGS &&
            out_data.speed_leg0 == 0 && out_data.speed_leg1 == 0 &&
            out_data.speed_leg2 == 0 && out_data.speed_leg3 == 0 &&
            out_data.speed_leg4 == 0 && out_data.speed_leg5 == 0)
        else $error("phase advance without full stop");

    // Uncommanded legs carry zero speed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_data.command_mask[0] || out_data.speed_leg0 == 0) &&
            (out_data.command_mask[1] || out_data.speed_leg1 == 0) &&
            (out_data.command_mask[2] || out_data.speed_leg2 == 0) &&
            (out_data.command_mask[3] || out_data.speed_leg3 == 0) &&
            (out_data.command_mask[4] || out_data.speed_leg4 == 0) &&
            (out_data.command_mask[5] || out_data.speed_leg5 == 0))
        else $error("speed on a leg without a command");

    // No result beat straight out of reset
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result beat right after reset");

endmodule

bind tripod_gait_sequencer_top tgs_checker u_tgs_checker (.*);
